>>> rtl/core/assert_macros.svh
// Assertion helpers shared by the core modules.
// Every macro samples on the rising edge of clk and is switched off while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property holds at every clock edge outside reset.
`define PBF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// When pre holds at one edge, post holds at the next edge.
`define PBF_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

>>> rtl/core/pbf_pkg.sv
`timescale 1ns / 1ps
package pbf_pkg;

  // Field widths of the item and result beats.
  localparam int POS_W      = 12;
  localparam int NUM_POS    = 8;
  localparam int STATUS_W   = 3;
  localparam int COUNT_W    = 21;
  localparam int NSLICE_W   = 4;
  localparam int SIZE_W     = 13;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 21;

  localparam logic [CFG_IDX_W-1:0] REG_SLICES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX    = 2'd2;

  // Register values after reset.
  localparam logic [NSLICE_W-1:0] RST_SLICES = 4'd1;
  localparam logic [SIZE_W-1:0]   RST_SIZE   = 13'd4096;
  localparam logic [COUNT_W-1:0]  RST_MAX    = 21'd1048576;

  // Default geometry of the bit store.
  localparam int DEF_MAX_SLICES = 8;
  localparam int DEF_SLICE_BITS = 4096;

  // Entries in the queue between the front and back parts.
  localparam int QUEUE_DEPTH = 2;

  // Item modes.
  localparam logic MODE_ADD  = 1'b0;
  localparam logic MODE_TEST = 1'b1;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_ADDED   = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_ABSENT  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_PRESENT = 3'd3;
  localparam logic [STATUS_W-1:0] ST_RANGE   = 3'd4;

  typedef logic [POS_W-1:0] pbf_pos_t;

  typedef struct packed {
    logic [NSLICE_W-1:0] slices_in_use;
    logic [SIZE_W-1:0]   slice_size;
    logic [COUNT_W-1:0]  max_inserts;
  } pbf_cfg_t;

  // A classified item as it waits in the queue.
  typedef struct packed {
    logic                    mode;
    logic                    in_range;
    logic [NUM_POS-1:0]      active;
    pbf_pos_t [NUM_POS-1:0]  pos;
  } pbf_item_t;

  typedef struct packed {
    logic empty;
    logic full;
  } pbf_qstat_t;

endpackage

>>> rtl/core/pbf_req_if.sv
`timescale 1ns / 1ps
interface pbf_req_if import pbf_pkg::*; ();
  logic     valid;
  logic     ready;
  logic     mode;
  pbf_pos_t pos_slice0;
  pbf_pos_t pos_slice1;
  pbf_pos_t pos_slice2;
  pbf_pos_t pos_slice3;
  pbf_pos_t pos_slice4;
  pbf_pos_t pos_slice5;
  pbf_pos_t pos_slice6;
  pbf_pos_t pos_slice7;

  modport source (
    output valid, mode, pos_slice0, pos_slice1, pos_slice2, pos_slice3,
           pos_slice4, pos_slice5, pos_slice6, pos_slice7,
    input  ready
  );

  modport sink (
    input  valid, mode, pos_slice0, pos_slice1, pos_slice2, pos_slice3,
           pos_slice4, pos_slice5, pos_slice6, pos_slice7,
    output ready
  );
endinterface

>>> rtl/core/pbf_rsp_if.sv
`timescale 1ns / 1ps
interface pbf_rsp_if import pbf_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [COUNT_W-1:0]  insert_total;

  modport source (
    output valid, status, insert_total,
    input  ready
  );

  modport sink (
    input  valid, status, insert_total,
    output ready
  );
endinterface

>>> rtl/core/pbf_ram.sv
`timescale 1ns / 1ps
module pbf_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/core/pbf_front.sv
`timescale 1ns / 1ps
module pbf_front import pbf_pkg::*; #(
  parameter int MAX_SLICES = DEF_MAX_SLICES,
  parameter int SLICE_BITS = DEF_SLICE_BITS
) (
  pbf_req_if.sink    req,
  input  pbf_cfg_t   cfg,
  input  logic       clearing,
  input  pbf_qstat_t qstat,
  output logic       push,
  output pbf_item_t  item
);

  logic [NSLICE_W-1:0] n_eff;
  pbf_pos_t            pos [NUM_POS];

  // Accept a beat whenever the queue has room and the store is not being cleared.
  assign req.ready = !qstat.full && !clearing;
  assign push      = req.valid && req.ready;

  assign pos[0] = req.pos_slice0;
  assign pos[1] = req.pos_slice1;
  assign pos[2] = req.pos_slice2;
  assign pos[3] = req.pos_slice3;
  assign pos[4] = req.pos_slice4;
  assign pos[5] = req.pos_slice5;
  assign pos[6] = req.pos_slice6;
  assign pos[7] = req.pos_slice7;

  // Slice count clamped to the range that the store supports.
  always_comb begin
    if (cfg.slices_in_use == '0) begin
      n_eff = NSLICE_W'(1);
    end else if (32'(cfg.slices_in_use) > MAX_SLICES) begin
      n_eff = NSLICE_W'(MAX_SLICES);
    end else begin
      n_eff = cfg.slices_in_use;
    end
  end

  // Mark the active slices and check every active position against the slice size.
  // A size of zero behaves as one bit, and the bank depth caps the size from above.
  always_comb begin
    logic below_size;
    logic below_bank;
    item.mode     = req.mode;
    item.in_range = 1'b1;
    for (int i = 0; i < NUM_POS; i++) begin
      item.pos[i]    = pos[i];
      item.active[i] = (NSLICE_W'(i) < n_eff);
      below_size     = (cfg.slice_size == '0) ? (pos[i] == '0)
                                              : (SIZE_W'(pos[i]) < cfg.slice_size);
      below_bank     = (32'(pos[i]) < SLICE_BITS);
      if (item.active[i] && !(below_size && below_bank)) begin
        item.in_range = 1'b0;
      end
    end
  end

endmodule

>>> rtl/core/pbf_queue.sv
`timescale 1ns / 1ps
module pbf_queue import pbf_pkg::*;
  `include "assert_macros.svh"
(
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  pbf_item_t  wr_item,
  input  logic       pop,
  output pbf_item_t  rd_item,
  output pbf_qstat_t qstat
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  pbf_item_t        slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign qstat.empty = (count == '0);
  assign qstat.full  = (count == CNT_W'(QUEUE_DEPTH));
  assign rd_item     = slots[rd_ptr];

  // Payload slots.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_item;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  `PBF_ASSERT(a_no_push_full, !(qstat.full && push), "push into a full queue")
  `PBF_ASSERT(a_no_pop_empty, !(qstat.empty && pop), "pop from an empty queue")
  `PBF_ASSERT_NEXT(a_count_up, push && !pop, count == $past(count) + CNT_W'(1), "queue count lost a push")

endmodule

>>> rtl/core/pbf_back.sv
`timescale 1ns / 1ps
module pbf_back import pbf_pkg::*;
  `include "assert_macros.svh"
#(
  parameter int MAX_SLICES = DEF_MAX_SLICES,
  parameter int SLICE_BITS = DEF_SLICE_BITS
) (
  input  logic       clk,
  input  logic       rst,
  input  pbf_cfg_t   cfg,
  input  pbf_qstat_t qstat,
  input  pbf_item_t  head,
  output logic       pop,
  output logic       clearing,
  pbf_rsp_if.source  rsp
);

  localparam int ADDR_W = $clog2(SLICE_BITS);

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_EVAL  = 2'd2;

  logic [1:0]          state;
  logic [1:0]          state_next;
  logic [ADDR_W-1:0]   clr_addr;
  pbf_item_t           cur;
  logic [COUNT_W-1:0]  insert_count;
  logic [COUNT_W-1:0]  count_next;
  logic                out_valid;
  logic [STATUS_W-1:0] out_status;
  logic [COUNT_W-1:0]  out_total;
  logic [STATUS_W-1:0] status_next;
  logic [NUM_POS-1:0]  rd_bits;
  logic [MAX_SLICES-1:0] bank_we;
  logic [ADDR_W-1:0]   bank_waddr [MAX_SLICES];
  logic [ADDR_W-1:0]   bank_raddr [MAX_SLICES];
  logic                bank_wdata;
  logic                fire;
  logic                full;
  logic                hit;
  logic                do_add;

  assign clearing   = (state == S_CLEAR);
  assign pop        = (state == S_IDLE) && !qstat.empty;
  assign fire       = (state == S_EVAL) && (!out_valid || rsp.ready);
  assign full       = (insert_count >= cfg.max_inserts);
  assign hit        = &(rd_bits | ~cur.active);
  assign bank_wdata = !clearing;

  // One bank per slice: read at the head of the queue on pop, written on an add or a clear.
  for (genvar b = 0; b < MAX_SLICES; b++) begin : g_bank
    assign bank_raddr[b] = ADDR_W'(head.pos[b]);
    assign bank_waddr[b] = clearing ? clr_addr : ADDR_W'(cur.pos[b]);
    assign bank_we[b]    = clearing || (do_add && cur.active[b]);

    pbf_ram #(
      .WIDTH (1),
      .DEPTH (SLICE_BITS)
    ) u_ram (
      .clk   (clk),
      .we    (bank_we[b]),
      .waddr (bank_waddr[b]),
      .wdata (bank_wdata),
      .re    (pop),
      .raddr (bank_raddr[b]),
      .rdata (rd_bits[b])
    );
  end

  // Slices without a bank never take part and read as set.
  for (genvar b = MAX_SLICES; b < NUM_POS; b++) begin : g_nobank
    assign rd_bits[b] = 1'b1;
  end

  // Result of the current item; a full filter wins over a range fault on an add.
  always_comb begin
    do_add      = 1'b0;
    status_next = ST_RANGE;
    if (cur.mode == MODE_ADD) begin
      if (full) begin
        status_next = ST_FULL;
      end else if (cur.in_range) begin
        status_next = ST_ADDED;
        do_add      = fire;
      end
    end else if (cur.in_range) begin
      status_next = hit ? ST_PRESENT : ST_ABSENT;
    end
  end

  assign count_next = do_add ? insert_count + COUNT_W'(1) : insert_count;

  // Sequencer: clearing pass, wait for an item, evaluate against the bank data.
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: if (clr_addr == ADDR_W'(SLICE_BITS - 1)) state_next = S_IDLE;
      S_IDLE:  if (pop) state_next = S_EVAL;
      S_EVAL:  if (fire) state_next = S_IDLE;
      default: state_next = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      clr_addr     <= '0;
      insert_count <= '0;
      out_valid    <= 1'b0;
    end else begin
      state        <= state_next;
      insert_count <= count_next;
      if (clearing) begin
        clr_addr <= clr_addr + ADDR_W'(1);
      end
      if (fire) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Item and result payload registers.
  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head;
    end
    if (fire) begin
      out_status <= status_next;
      out_total  <= count_next;
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.status       = out_status;
  assign rsp.insert_total = out_total;

  `PBF_ASSERT(a_no_pop_clear, !(clearing && pop), "item taken during the clearing pass")
  `PBF_ASSERT(a_we_window, !(|bank_we) || state == S_CLEAR || state == S_EVAL, "bank written outside clear or evaluate")
  `PBF_ASSERT_NEXT(a_count_step, do_add, insert_count == $past(insert_count) + COUNT_W'(1), "add did not count")

endmodule

>>> rtl/core/partitioned_bloom_filter_core.sv
`timescale 1ns / 1ps
// Channel   Dir  Handshake          Beat contents
// req       in   req.valid/ready    mode, pos_slice0 .. pos_slice7
// rsp       out  rsp.valid/ready    status, insert_total
// cfg       in   cfg_we             cfg_index, cfg_data (write only)
//
// After reset a clearing pass writes every bank, one address a cycle; req.ready stays
// low during the pass while configuration writes are taken.
// Each item takes two steps in the back part: one bank read, then evaluate and write.
// A two-entry queue lets req accept while an item is being evaluated.
// A stalled rsp holds its beat and stops evaluation; the queue then fills and req stalls.
module partitioned_bloom_filter_core import pbf_pkg::*; #(
  parameter int MAX_SLICES = DEF_MAX_SLICES,
  parameter int SLICE_BITS = DEF_SLICE_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  pbf_req_if.sink               req,
  pbf_rsp_if.source             rsp
);

  pbf_cfg_t   cfg;
  pbf_item_t  wr_item;
  pbf_item_t  head;
  pbf_qstat_t qstat;
  logic       push;
  logic       pop;
  logic       clearing;

  // Configuration registers; writes to an unused index are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.slices_in_use <= RST_SLICES;
      cfg.slice_size    <= RST_SIZE;
      cfg.max_inserts   <= RST_MAX;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SLICES: cfg.slices_in_use <= cfg_data[NSLICE_W-1:0];
        REG_SIZE:   cfg.slice_size    <= cfg_data[SIZE_W-1:0];
        REG_MAX:    cfg.max_inserts   <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  pbf_front #(
    .MAX_SLICES (MAX_SLICES),
    .SLICE_BITS (SLICE_BITS)
  ) u_front (
    .req      (req),
    .cfg      (cfg),
    .clearing (clearing),
    .qstat    (qstat),
    .push     (push),
    .item     (wr_item)
  );

  pbf_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_item (wr_item),
    .pop     (pop),
    .rd_item (head),
    .qstat   (qstat)
  );

  pbf_back #(
    .MAX_SLICES (MAX_SLICES),
    .SLICE_BITS (SLICE_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .qstat    (qstat),
    .head     (head),
    .pop      (pop),
    .clearing (clearing),
    .rsp      (rsp)
  );

endmodule
